// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers shared by the fixup RTL.
// Define NO_ASSERTIONS to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property that must hold at every clock edge outside reset.
`define USF_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define USF_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`else

`define USF_ASSERT(lbl, clk, rstn, prop, msg)
`define USF_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

// ----- hw/rtl/usf_pkg.sv -----
`default_nettype none

package usf_pkg;

    // Default sizing of the record buffer and of one sector.
    localparam int DEF_MAX_RECORD_BYTES = 4096;
    localparam int DEF_SECTOR_BYTES     = 512;

    // Fixed header layout of a record.
    localparam int HDR_OFFSET_POS   = 4;
    localparam int HDR_COUNT_POS    = 6;
    localparam int MIN_RECORD_BYTES = 8;

    // Action codes of an input beat.
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_READ = 1'b1;

    // Kinds of result beat.
    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_DATA   = 1'b1;

    // Status codes reported after a record closes.
    typedef enum logic [2:0] {
        STATUS_OK           = 3'd0,
        STATUS_COUNT_ZERO   = 3'd1,
        STATUS_ARRAY_PAST   = 3'd2,
        STATUS_SECTORS_PAST = 3'd3,
        STATUS_BAD_LENGTH   = 3'd4
    } usf_status_t;

    // Input beat.
    typedef struct packed {
        logic        action;
        logic [7:0]  byte_value;
        logic        last;
        logic [11:0] read_index;
    } usf_in_t;

    // Result beat.
    typedef struct packed {
        logic        result_kind;
        usf_status_t status;
        logic        applied;
        logic [12:0] record_length;
        logic [7:0]  data_byte;
    } usf_out_t;

    // Sequencer states: idle, read-back, header fetch, checks, sequence number
    // fetch, the per-sector compare and repair loop and the result state.
    typedef enum logic [4:0] {
        S_IDLE,
        S_RD,
        S_H0,
        S_H1,
        S_H2,
        S_H3,
        S_H4,
        S_CHK,
        S_U1,
        S_U2,
        S_L0,
        S_L1,
        S_L2,
        S_L3,
        S_L4,
        S_L5,
        S_FIN
    } usf_state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/usf_chan_if.sv -----
`default_nettype none

// Valid/ready channel carrying one payload per beat.
interface usf_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/usf_ram.sv -----
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module usf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output      logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ----- hw/rtl/usf_ctrl.sv -----
`default_nettype none

`include "assert_macros.svh"

// Load, check and repair sequencer. Owns the record length state and drives
// both ports of the record RAM.
module usf_ctrl #(
    parameter int MAX_RECORD_BYTES = 4096,
    parameter int SECTOR_BYTES     = 512
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    input  wire usf_pkg::usf_in_t                    in_item,
    output      logic                                in_ready,
    output      logic                                res_valid,
    output      usf_pkg::usf_out_t                   res_item,
    input  wire logic                                res_free,
    output      logic                                mem_wr_en,
    output      logic [$clog2(MAX_RECORD_BYTES)-1:0] mem_wr_addr,
    output      logic [7:0]                          mem_wr_data,
    output      logic [$clog2(MAX_RECORD_BYTES)-1:0] mem_rd_addr,
    input  wire logic [7:0]                          mem_rd_data
);

    import usf_pkg::*;

    localparam int AW = $clog2(MAX_RECORD_BYTES);
    localparam int CW = $clog2(MAX_RECORD_BYTES + 1);

    usf_state_t  state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic          closed_reg, closed_next;
    logic [15:0]   off_reg, off_next;
    logic [15:0]   entries_reg, entries_next;
    logic [15:0]   usn_reg, usn_next;
    logic [15:0]   saved_reg, saved_next;
    logic [7:0]    tail_lo_reg, tail_lo_next;
    logic [AW-1:0] tail_pos_reg, tail_pos_next;
    logic [AW-1:0] arr_ptr_reg, arr_ptr_next;
    logic [15:0]   remain_reg, remain_next;
    logic [AW-1:0] rd_addr_reg, rd_addr_next;
    logic          zero_reg, zero_next;
    usf_status_t   status_reg, status_next;
    logic          applied_reg, applied_next;

    logic          accept;
    logic          close_beat;
    logic [CW-1:0] count_base;
    logic          ovf_base;
    logic          array_past;
    logic          sectors_past;
    logic [31:0]   sector_span;

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            ovf_reg    <= 1'b0;
            closed_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            ovf_reg    <= ovf_next;
            closed_reg <= closed_next;
        end
    end

    // Walk datapath registers.
    always_ff @(posedge clk)
    begin
        off_reg      <= off_next;
        entries_reg  <= entries_next;
        usn_reg      <= usn_next;
        saved_reg    <= saved_next;
        tail_lo_reg  <= tail_lo_next;
        tail_pos_reg <= tail_pos_next;
        arr_ptr_reg  <= arr_ptr_next;
        remain_reg   <= remain_next;
        rd_addr_reg  <= rd_addr_next;
        zero_reg     <= zero_next;
        status_reg   <= status_next;
        applied_reg  <= applied_next;
    end

    // A load after a closed record starts a new one.
    assign count_base = closed_reg ? '0 : count_reg;
    assign ovf_base   = closed_reg ? 1'b0 : ovf_reg;

    // Header checks on the fetched offset and entry count.
    assign sector_span  = 32'(entries_reg - 16'd1) * 32'(SECTOR_BYTES);
    assign array_past   = (32'(off_reg) + (32'(entries_reg) << 1)) > 32'(count_reg);
    assign sectors_past = (entries_reg > 16'd1) && (sector_span > 32'(count_reg));

    assign in_ready   = (state_reg == S_IDLE);
    assign accept     = in_valid && in_ready;
    assign close_beat = accept && (in_item.action == ACT_LOAD) && in_item.last;

    // Next state, RAM accesses and result.
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        ovf_next      = ovf_reg;
        closed_next   = closed_reg;
        off_next      = off_reg;
        entries_next  = entries_reg;
        usn_next      = usn_reg;
        saved_next    = saved_reg;
        tail_lo_next  = tail_lo_reg;
        tail_pos_next = tail_pos_reg;
        arr_ptr_next  = arr_ptr_reg;
        remain_next   = remain_reg;
        rd_addr_next  = rd_addr_reg;
        zero_next     = zero_reg;
        status_next   = status_reg;
        applied_next  = applied_reg;

        mem_wr_en   = 1'b0;
        mem_wr_addr = AW'(count_base);
        mem_wr_data = in_item.byte_value;
        mem_rd_addr = rd_addr_reg;

        res_valid = 1'b0;
        res_item  = '{result_kind:   KIND_STATUS,
                      status:        status_reg,
                      applied:       applied_reg,
                      record_length: 13'(count_reg),
                      data_byte:     8'd0};

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (in_item.action == ACT_LOAD))
                begin
                    // Store the byte, or note that the record ran long.
                    count_next = count_base;
                    ovf_next   = ovf_base;
                    if (count_base < CW'(MAX_RECORD_BYTES))
                    begin
                        mem_wr_en  = 1'b1;
                        count_next = count_base + CW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    closed_next = 1'b0;
                    if (in_item.last)
                    begin
                        closed_next  = 1'b1;
                        status_next  = STATUS_OK;
                        applied_next = 1'b0;
                        if (ovf_next || (32'(count_next) < 32'(MIN_RECORD_BYTES)))
                        begin
                            status_next = STATUS_BAD_LENGTH;
                            state_next  = S_FIN;
                        end
                        else
                        begin
                            state_next = S_H0;
                        end
                    end
                end
                else if (accept)
                begin
                    // Read-back: bytes past the record read as zero. The RAM
                    // address goes out now so the data is there in S_RD.
                    mem_rd_addr  = AW'(in_item.read_index);
                    rd_addr_next = AW'(in_item.read_index);
                    zero_next    = !(32'(in_item.read_index) < 32'(count_reg));
                    state_next   = S_RD;
                end
            end

            S_RD:
            begin
                res_valid = 1'b1;
                res_item  = '{result_kind:   KIND_DATA,
                              status:        STATUS_OK,
                              applied:       1'b0,
                              record_length: 13'(count_reg),
                              data_byte:     zero_reg ? 8'd0 : mem_rd_data};
                if (res_free)
                begin
                    state_next = S_IDLE;
                end
            end

            // Header fetch: offset word, then entry count word.
            S_H0:
            begin
                mem_rd_addr = AW'(HDR_OFFSET_POS);
                state_next  = S_H1;
            end

            S_H1:
            begin
                mem_rd_addr   = AW'(HDR_OFFSET_POS + 1);
                off_next[7:0] = mem_rd_data;
                state_next    = S_H2;
            end

            S_H2:
            begin
                mem_rd_addr    = AW'(HDR_COUNT_POS);
                off_next[15:8] = mem_rd_data;
                state_next     = S_H3;
            end

            S_H3:
            begin
                mem_rd_addr       = AW'(HDR_COUNT_POS + 1);
                entries_next[7:0] = mem_rd_data;
                state_next        = S_H4;
            end

            S_H4:
            begin
                entries_next[15:8] = mem_rd_data;
                state_next         = S_CHK;
            end

            S_CHK:
            begin
                // Fetch the sequence number while the checks settle.
                mem_rd_addr   = AW'(off_reg);
                arr_ptr_next  = AW'(off_reg) + AW'(2);
                tail_pos_next = AW'(SECTOR_BYTES - 2);
                remain_next   = entries_reg - 16'd1;
                if (entries_reg == 16'd0)
                begin
                    status_next = STATUS_COUNT_ZERO;
                    state_next  = S_FIN;
                end
                else if (array_past)
                begin
                    status_next = STATUS_ARRAY_PAST;
                    state_next  = S_FIN;
                end
                else if (sectors_past)
                begin
                    status_next = STATUS_SECTORS_PAST;
                    state_next  = S_FIN;
                end
                else if (entries_reg == 16'd1)
                begin
                    applied_next = 1'b1;
                    state_next   = S_FIN;
                end
                else
                begin
                    state_next = S_U1;
                end
            end

            S_U1:
            begin
                mem_rd_addr   = AW'(off_reg) + AW'(1);
                usn_next[7:0] = mem_rd_data;
                state_next    = S_U2;
            end

            S_U2:
            begin
                mem_rd_addr    = arr_ptr_reg;
                usn_next[15:8] = mem_rd_data;
                state_next     = S_L1;
            end

            // Sector loop: saved word, tail word, compare, write back.
            S_L0:
            begin
                mem_rd_addr = arr_ptr_reg;
                state_next  = S_L1;
            end

            S_L1:
            begin
                mem_rd_addr     = arr_ptr_reg + AW'(1);
                saved_next[7:0] = mem_rd_data;
                state_next      = S_L2;
            end

            S_L2:
            begin
                mem_rd_addr      = tail_pos_reg;
                saved_next[15:8] = mem_rd_data;
                state_next       = S_L3;
            end

            S_L3:
            begin
                mem_rd_addr  = tail_pos_reg + AW'(1);
                tail_lo_next = mem_rd_data;
                state_next   = S_L4;
            end

            S_L4:
            begin
                if ({mem_rd_data, tail_lo_reg} != usn_reg)
                begin
                    // Mismatch ends the walk; earlier sectors stay repaired.
                    state_next = S_FIN;
                end
                else
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = tail_pos_reg;
                    mem_wr_data = saved_reg[7:0];
                    state_next  = S_L5;
                end
            end

            S_L5:
            begin
                mem_wr_en     = 1'b1;
                mem_wr_addr   = tail_pos_reg + AW'(1);
                mem_wr_data   = saved_reg[15:8];
                tail_pos_next = tail_pos_reg + AW'(SECTOR_BYTES);
                arr_ptr_next  = arr_ptr_reg + AW'(2);
                remain_next   = remain_reg - 16'd1;
                if (remain_reg == 16'd1)
                begin
                    applied_next = 1'b1;
                    state_next   = S_FIN;
                end
                else
                begin
                    state_next = S_L0;
                end
            end

            S_FIN:
            begin
                res_valid = 1'b1;
                if (res_free)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `USF_NEVER(a_count_bound, clk, rst_n, count_reg > CW'(MAX_RECORD_BYTES), "length too big")
    `USF_ASSERT(a_ovf_full, clk, rst_n, ovf_reg |-> (count_reg == CW'(MAX_RECORD_BYTES)), "ovf")
    `USF_ASSERT(a_close_walk, clk, rst_n, close_beat |=> (state_reg inside {S_H0, S_FIN}), "walk")
    `USF_ASSERT(a_result_done, clk, rst_n, (res_valid && res_free) |=> (state_reg == S_IDLE), "busy")

endmodule

`default_nettype wire

// ----- hw/rtl/update_sequence_fixup_unit.sv -----
`default_nettype none

// Update sequence array fixup for multi-sector records. Load beats
// (action 0) are taken one per cycle while the sequencer is idle and write
// one record byte each; a byte past the buffer only marks the record as
// overflowed. The beat marked last closes the record and gives one status
// beat: a too short or overflowed record goes straight to its status, any
// other starts the check and repair walk, which reads the record RAM one byte
// at a time through its single read port. A header error or a single-entry
// array ends the walk after the header fetch and checks; a full walk goes on
// to the sequence number fetch and the sector loop, ending early on a tail
// mismatch. A read-back beat (action 1) has its RAM address issued as the
// beat is taken. The sequencer is idle again once its result enters the
// output register. No new beat is taken while a walk or a read-back is in
// progress; a finished result sits in the output register until taken.
module update_sequence_fixup_unit #(
    parameter int MAX_RECORD_BYTES = usf_pkg::DEF_MAX_RECORD_BYTES,
    parameter int SECTOR_BYTES     = usf_pkg::DEF_SECTOR_BYTES
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    usf_chan_if.sink   request,
    usf_chan_if.source result
);

    import usf_pkg::*;

    localparam int AW = $clog2(MAX_RECORD_BYTES);

    logic          res_valid;
    usf_out_t      res_item;
    logic          res_free;
    logic          mem_wr_en;
    logic [AW-1:0] mem_wr_addr;
    logic [7:0]    mem_wr_data;
    logic [AW-1:0] mem_rd_addr;
    logic [7:0]    mem_rd_data;
    logic          out_valid_reg;
    usf_out_t      out_item_reg;

    // Record buffer.
    usf_ram #(
        .WIDTH (8),
        .DEPTH (MAX_RECORD_BYTES)
    ) u_ram (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // Load, check and repair sequencer.
    usf_ctrl #(
        .MAX_RECORD_BYTES (MAX_RECORD_BYTES),
        .SECTOR_BYTES     (SECTOR_BYTES)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (request.valid),
        .in_item     (request.payload),
        .in_ready    (request.ready),
        .res_valid   (res_valid),
        .res_item    (res_item),
        .res_free    (res_free),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    // Output register: free when empty or when its beat leaves this cycle.
    assign res_free = !out_valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_free)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_free && res_valid)
        begin
            out_item_reg <= res_item;
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.payload = out_item_reg;

endmodule

`default_nettype wire
